[rtl/g6esd_pkg.sv]
// ----------------------------------------------------------------------------
// g6esd_pkg
// Shared types, constants and helpers for the graph6 line decoder.
// ----------------------------------------------------------------------------
package g6esd_pkg;

	localparam int MAX_VERTICES = 62;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [7:0] CHAR_BIAS = 8'd63;
	localparam logic [7:0] CHAR_TOP  = 8'd126;
	localparam logic [8:0] BODY_MAX  = 9'd511;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_BAD    = 3'd1;
	localparam logic [2:0] ST_COUNT  = 3'd2;
	localparam logic [2:0] ST_LENGTH = 3'd3;
	localparam logic [2:0] ST_EMPTY  = 3'd4;

	localparam logic RK_EDGE   = 1'b0;
	localparam logic RK_STATUS = 1'b1;

	// one classified item waiting for the back end
	typedef struct packed {
		logic [5:0]  bits;
		logic        body;
		logic        fin;
		logic [2:0]  st;
		logic [5:0]  vc;
		logic [10:0] total;
	} q_entry_t;

	typedef struct packed {
		logic        kind;
		logic [5:0]  lo;
		logic [5:0]  hi;
		logic [2:0]  st;
		logic [5:0]  vc;
		logic [10:0] et;
		logic        last;
	} result_t;

	// number of vertex pairs n(n-1)/2
	function automatic logic [10:0] pair_count(input logic [5:0] n);
		logic [5:0]  nm1;
		logic [11:0] prod;
		nm1  = (n == 6'd0) ? 6'd0 : n - 6'd1;
		prod = 12'(n) * 12'(nm1);
		return prod[11:1];
	endfunction

endpackage

[rtl/g6esd_front.sv]
// ----------------------------------------------------------------------------
// g6esd_front
// Accepts characters, tracks header, length and error state, queues work.
// ----------------------------------------------------------------------------
module g6esd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           char_byte,
	input  logic                 has_char,
	input  logic                 line_end,
	output logic                 push_valid,
	input  logic                 push_ready,
	output g6esd_pkg::q_entry_t  push_data
);
	import g6esd_pkg::*;

	logic        header_q;
	logic [5:0]  count_q;
	logic [10:0] total_q;
	logic [8:0]  body_q;
	logic [2:0]  err_q;

	logic        good;
	logic [7:0]  diff;
	logic [6:0]  val;
	logic        hdr_n;
	logic [5:0]  cnt_n;
	logic [10:0] tot_n;
	logic [8:0]  body_n;
	logic [2:0]  err_n;
	logic        body_go;
	logic [11:0] body_x6;
	logic [11:0] tot_x;
	logic        len_ok;
	logic [2:0]  st;
	logic        accept;

	always_comb begin
		good    = (char_byte >= CHAR_BIAS) && (char_byte <= CHAR_TOP);
		diff    = char_byte - CHAR_BIAS;
		val     = good ? diff[6:0] : 7'd0;
		hdr_n   = header_q;
		cnt_n   = count_q;
		tot_n   = total_q;
		body_n  = body_q;
		err_n   = err_q;
		body_go = 1'b0;
		if (has_char) begin
			if (!header_q) begin
				hdr_n = 1'b1;
				if (!good) begin
					if (err_n == ST_OK) err_n = ST_BAD;
				end else if (val > 7'(MAX_VERTICES)) begin
					if (err_n == ST_OK) err_n = ST_COUNT;
				end else begin
					cnt_n = val[5:0];
				end
				tot_n = pair_count(cnt_n);
			end else begin
				if (body_q != BODY_MAX) body_n = body_q + 9'd1;
				if (!good && err_n == ST_OK) err_n = ST_BAD;
				body_go = (err_n == ST_OK);
			end
		end
		// body length must be ceil(total/6): 6*len - 6 < total <= 6*len
		body_x6 = {2'b00, body_n, 1'b0} + {1'b0, body_n, 2'b00};
		tot_x   = {1'b0, tot_n};
		len_ok  = (tot_x <= body_x6) && ((tot_x + 12'd6) > body_x6);
		if (!hdr_n)
			st = ST_EMPTY;
		else if (err_n == ST_OK && !len_ok)
			st = ST_LENGTH;
		else
			st = err_n;

		push_data.bits  = val[5:0];
		push_data.body  = body_go;
		push_data.fin   = line_end;
		push_data.st    = st;
		push_data.vc    = cnt_n;
		push_data.total = tot_n;
	end

	assign push_valid = in_valid && (body_go || line_end);
	assign in_ready   = push_ready;
	assign accept     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= 1'b0;
			count_q  <= '0;
			total_q  <= '0;
			body_q   <= '0;
			err_q    <= ST_OK;
		end else if (accept) begin
			if (line_end) begin
				header_q <= 1'b0;
				count_q  <= '0;
				total_q  <= '0;
				body_q   <= '0;
				err_q    <= ST_OK;
			end else begin
				header_q <= hdr_n;
				count_q  <= cnt_n;
				total_q  <= tot_n;
				body_q   <= body_n;
				err_q    <= err_n;
			end
		end
	end

endmodule

[rtl/g6esd_queue.sv]
// ----------------------------------------------------------------------------
// g6esd_queue
// Short register queue between the front and back ends.
// ----------------------------------------------------------------------------
module g6esd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  g6esd_pkg::q_entry_t  push_data,
	output logic                 head_valid,
	input  logic                 pop,
	output g6esd_pkg::q_entry_t  head
);
	import g6esd_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	q_entry_t      mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (cnt_q != (PW+1)'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + PW'(1);
			if (do_pop) rd_q <= rd_q + PW'(1);
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (PW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (PW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/g6esd_back.sv]
// ----------------------------------------------------------------------------
// g6esd_back
// Walks the vertex pairs one bit per cycle unless the output stalls, and drives the result register.
// ----------------------------------------------------------------------------
module g6esd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  g6esd_pkg::q_entry_t  head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output g6esd_pkg::result_t   res
);
	import g6esd_pkg::*;

	localparam logic [2:0] BPOS_LAST = 3'd5;
	localparam logic [2:0] BPOS_DONE = 3'd6;

	logic [5:0]  col_low_q;
	logic [5:0]  col_high_q;
	logic [10:0] pair_q;
	logic [10:0] edges_q;
	logic [2:0]  bpos_q;
	logic        ov_q;
	result_t     res_q;

	logic        out_free;
	logic        body_act;
	logic [2:0]  cur;
	logic        emit;
	logic [10:0] rem_full;
	logic [2:0]  rem;
	logic        more;
	logic        last_step;
	logic        step;
	logic        do_status;
	logic        load;
	result_t     nres;
	logic [5:0]  low_n;
	logic [5:0]  high_n;

	always_comb begin
		out_free  = !ov_q || out_ready;
		body_act  = head.body && (bpos_q != BPOS_DONE) && (pair_q < head.total);
		cur       = BPOS_LAST - bpos_q;
		emit      = head.bits[cur];
		rem_full  = head.total - pair_q - 11'd1;
		rem       = (rem_full > 11'd7) ? 3'd7 : rem_full[2:0];
		// any set bit later in this character that still maps to a pair
		more = 1'b0;
		for (int i = 0; i < 6; i++) begin
			if ((3'(i) < cur) && ((cur - 3'(i)) <= rem) && head.bits[i]) more = 1'b1;
		end
		last_step = (bpos_q == BPOS_LAST) || (rem_full == 11'd0);

		step      = 1'b0;
		do_status = 1'b0;
		pop       = 1'b0;
		if (head_valid) begin
			if (body_act) begin
				step = !emit || out_free;
				pop  = step && last_step && !head.fin;
			end else if (head.fin) begin
				do_status = out_free;
				pop       = out_free;
			end else begin
				pop = 1'b1;
			end
		end
		load = (step && emit) || do_status;

		if (do_status) begin
			nres.kind = RK_STATUS;
			nres.lo   = '0;
			nres.hi   = '0;
			nres.st   = head.st;
			nres.vc   = head.vc;
			nres.et   = edges_q;
			nres.last = 1'b1;
		end else begin
			nres.kind = RK_EDGE;
			nres.lo   = col_low_q;
			nres.hi   = col_high_q;
			nres.st   = ST_OK;
			nres.vc   = head.vc;
			nres.et   = edges_q + 11'd1;
			nres.last = !more && !head.fin;
		end

		// column order walk
		if ((col_high_q - col_low_q) > 6'd1) begin
			low_n  = col_low_q + 6'd1;
			high_n = col_high_q;
		end else begin
			low_n  = 6'd0;
			high_n = col_high_q + 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_low_q  <= 6'd0;
			col_high_q <= 6'd1;
			pair_q     <= '0;
			edges_q    <= '0;
			bpos_q     <= '0;
			ov_q       <= 1'b0;
		end else begin
			if (step) begin
				col_low_q  <= low_n;
				col_high_q <= high_n;
				pair_q     <= pair_q + 11'd1;
				if (emit) edges_q <= edges_q + 11'd1;
				if (!last_step) bpos_q <= bpos_q + 3'd1;
				else if (head.fin) bpos_q <= BPOS_DONE;
				else bpos_q <= '0;
			end else if (do_status) begin
				col_low_q  <= 6'd0;
				col_high_q <= 6'd1;
				pair_q     <= '0;
				edges_q    <= '0;
				bpos_q     <= '0;
			end else if (pop) begin
				bpos_q <= '0;
			end
			if (out_free) ov_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load) res_q <= nres;
	end

	assign out_valid = ov_q;
	assign res       = res_q;

endmodule

[rtl/graph6_edge_stream_decoder.sv]
// ----------------------------------------------------------------------------
// graph6_edge_stream_decoder
// Decodes a graph6 line into edge results and one end-of-line status.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   char_byte, has_char, line_end
//  out      output     out_valid / out_ready result_kind, low_vertex, high_vertex,
//                                            status, num_vertices, edge_total,
//                                            last_of_run
//
//  the front takes one item per cycle while its 4-entry queue has room
//  the back walks one vertex pair per cycle unless the output stalls: a body
//  character covers up to six pairs, and a line end adds the status result
//  reset clears all line state; no clearing pass
//  out_ready low stalls the back only; the front keeps filling the queue
// ----------------------------------------------------------------------------
module graph6_edge_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_byte,
	input  logic        has_char,
	input  logic        line_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [5:0]  low_vertex,
	output logic [5:0]  high_vertex,
	output logic [2:0]  status,
	output logic [5:0]  num_vertices,
	output logic [10:0] edge_total,
	output logic        last_of_run
);
	import g6esd_pkg::*;

	logic     push_valid;
	logic     push_ready;
	q_entry_t push_data;
	logic     head_valid;
	logic     pop;
	q_entry_t head;
	result_t  res;

	g6esd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_byte  (char_byte),
		.has_char   (has_char),
		.line_end   (line_end),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	g6esd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.head_valid (head_valid),
		.pop        (pop),
		.head       (head)
	);

	g6esd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.res        (res)
	);

	assign result_kind  = res.kind;
	assign low_vertex   = res.lo;
	assign high_vertex  = res.hi;
	assign status       = res.st;
	assign num_vertices = res.vc;
	assign edge_total   = res.et;
	assign last_of_run  = res.last;

`ifndef ASSERT_OFF
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == RK_STATUS |-> last_of_run)
		else $error("status result without last_of_run");

	a_edge_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == RK_EDGE |-> low_vertex < high_vertex
			&& status == ST_OK && edge_total != 11'd0)
		else $error("malformed edge result");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == RK_STATUS |-> low_vertex == 6'd0
			&& high_vertex == 6'd0)
		else $error("status result carries vertices");

	a_pop_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");
`endif

endmodule
